// ===== design/subseq_pkg.sv =====
// ----------------------------------------------------------------------------
// Subsequence checker package
// Shared request codes, the symbol width and the result record type.
// ----------------------------------------------------------------------------
`default_nettype none

package subseq_pkg;

   // Width of one pattern or text symbol.
   localparam int SYMBOL_W = 8;

   // Request kinds carried on the req_type field.
   localparam logic REQ_PATTERN = 1'b0;
   localparam logic REQ_TEXT    = 1'b1;

   // One result record as held in the output stage.
   typedef struct packed {
      logic found;
      logic pattern_overflow;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/subseq_ram.sv =====
// ----------------------------------------------------------------------------
// Subsequence checker RAM
// Generic single-port-write, single-port-read memory with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module subseq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/subsequence_checker_top.sv =====
// ----------------------------------------------------------------------------
// Subsequence checker top level
// Checks whether a stored pattern string is a subsequence of a text stream.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req_ channel (valid/ready). A transfer with
// req_type = pattern writes req_symbol into the pattern RAM; the transfer
// with req_is_last set fixes the pattern length and rewinds the match
// pointer. Pattern bytes beyond MAX_PATTERN are dropped and flagged.
// A transfer with req_type = text compares req_symbol with the pattern byte
// at the match pointer and advances the pointer on equality. The last text
// byte produces one transfer on the rsp_ channel with rsp_found and
// rsp_pattern_overflow, and rewinds the pointer.
// Throughput is one request per cycle while req_ready is high. The pattern
// byte under the pointer is read from the registered RAM, addressed by the
// next pointer value; compare, increment and the RAM address form the single
// loop per byte. A write that hits the address being read is forwarded
// around the RAM. A result goes to the output register, or to the skid
// register while that is full and not draining. The two registers decouple
// the channels: req_ready only drops when both are full because rsp_ready
// stayed low. Reset clears all counters and the output stage; the pattern
// RAM is not cleared, and a text before any pattern reports found = 1.
// ----------------------------------------------------------------------------
`default_nettype none

module subsequence_checker_top #(
   parameter int MAX_PATTERN = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_type,
   input  wire logic [subseq_pkg::SYMBOL_W-1:0] req_symbol,
   input  wire logic                           req_is_last,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_found,
   output logic                                rsp_pattern_overflow
);

   // Address width of the pattern RAM and width of counts up to MAX_PATTERN.
   localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_PATTERN);
   localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);

   // Control state.
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] load_ff, load_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             ovf_ff, ovf_in;

   // Forwarding of a write that collides with the read address.
   logic                             fwd_valid_ff, fwd_valid_in;
   logic [subseq_pkg::SYMBOL_W-1:0]  fwd_data_ff;

   // Output register and skid register.
   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   subseq_pkg::rsp_type  main_ff, main_in;
   subseq_pkg::rsp_type  skid_ff, skid_in;

   // RAM connections.
   logic                             wr_en;
   logic [ADDR_W-1:0]                wr_addr;
   logic [ADDR_W-1:0]                rd_addr;
   logic [subseq_pkg::SYMBOL_W-1:0]  rd_data;
   logic [subseq_pkg::SYMBOL_W-1:0]  cur_symbol;

   logic                 accept;
   logic                 is_text;
   logic                 room;
   logic                 advance;
   logic [CNT_W-1:0]     load_after;
   logic [CNT_W-1:0]     ptr_after;
   logic                 res_valid;
   subseq_pkg::rsp_type  res;
   logic                 out_fire;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign is_text   = (req_type == subseq_pkg::REQ_TEXT);
   assign out_fire  = main_valid_ff && rsp_ready;

   // The pattern byte under the pointer, with a just-written byte forwarded.
   assign cur_symbol = fwd_valid_ff ? fwd_data_ff : rd_data;

   // Pattern loading.
   assign room       = (load_ff < MAX_COUNT);
   assign wr_en      = accept && !is_text && room;
   assign wr_addr    = load_ff[ADDR_W-1:0];
   assign load_after = room ? (load_ff + ONE) : load_ff;

   // Text matching.
   assign advance   = (ptr_ff < len_ff) && (cur_symbol == req_symbol);
   assign ptr_after = advance ? (ptr_ff + ONE) : ptr_ff;

   assign res_valid            = accept && is_text && req_is_last;
   assign res.found            = (ptr_after == len_ff);
   assign res.pattern_overflow = ovf_ff;

   always_comb begin
      len_in  = len_ff;
      load_in = load_ff;
      ptr_in  = ptr_ff;
      ovf_in  = ovf_ff;
      if (accept) begin
         if (is_text) begin
            ptr_in = req_is_last ? '0 : ptr_after;
         end else begin
            // The first byte of a new pattern clears the flag of the old one.
            if (load_ff == '0) begin
               ovf_in = 1'b0;
            end
            if (!room) begin
               ovf_in = 1'b1;
            end
            load_in = load_after;
            if (req_is_last) begin
               len_in  = load_after;
               load_in = '0;
               ptr_in  = '0;
            end
         end
      end
   end

   // The RAM is always addressed by the next pointer value.
   assign rd_addr      = ptr_in[ADDR_W-1:0];
   assign fwd_valid_in = wr_en && (wr_addr == rd_addr);

   // Output stage: a result goes to the output register when it is free or
   // draining, otherwise to the skid register.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_fire) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!main_valid_ff || out_fire) begin
            main_in       = res;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_fire) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         load_ff       <= '0;
         ptr_ff        <= '0;
         ovf_ff        <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         len_ff        <= len_in;
         load_ff       <= load_in;
         ptr_ff        <= ptr_in;
         ovf_ff        <= ovf_in;
         fwd_valid_ff  <= fwd_valid_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= req_symbol;
      main_ff     <= main_in;
      skid_ff     <= skid_in;
   end

   subseq_ram #(
      .WIDTH (subseq_pkg::SYMBOL_W),
      .DEPTH (MAX_PATTERN)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_symbol),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid            = main_valid_ff;
   assign rsp_found            = main_ff.found;
   assign rsp_pattern_overflow = main_ff.pattern_overflow;

`ifndef SYNTHESIS
   // The match pointer never runs past the pattern length.
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= len_ff)
      else $error("match pointer beyond pattern length");

   // Load count and pattern length stay within capacity.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (load_ff <= MAX_COUNT) && (len_ff <= MAX_COUNT))
      else $error("pattern count beyond capacity");

   // The skid register only holds a result behind a full output register.
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid register full with output register empty");

   // A last text byte always yields a result and rewinds the pointer.
   a_text_end: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> (main_valid_ff && (ptr_ff == '0)))
      else $error("last text byte did not produce a result");

   // A forwarded byte is only used when a write hit the read address.
   a_fwd: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> $past(wr_en))
      else $error("forwarding without a write");
`endif

endmodule

`default_nettype wire

// ===== dv/subseq_match_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subsequence match scoreboard
// Follows every request transfer with its own copy of the pattern store and
// match pointer, queues the verdict each last text byte should produce and
// compares every response transfer against the oldest queued verdict.
// ----------------------------------------------------------------------------
module subseq_match_checker #(
   parameter int MAX_PATTERN = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_type,
   input  logic [subseq_pkg::SYMBOL_W-1:0] req_symbol,
   input  logic                            req_is_last,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_found,
   input  logic                            rsp_pattern_overflow,
   output int                              fail_count,
   output int                              pending_count
);

   localparam int COUNT_W = $clog2(MAX_PATTERN + 1);

   logic [subseq_pkg::SYMBOL_W-1:0] pattern_mem [MAX_PATTERN];
   logic [COUNT_W-1:0]              pattern_len = '0;
   logic [COUNT_W-1:0]              load_count = '0;
   logic [COUNT_W-1:0]              match_ptr = '0;
   logic                            overflow_flag = 1'b0;
   subseq_pkg::rsp_type             verdict_q[$];
   int                              mismatches = 0;

   // Updates the pattern and pointer state for one accepted request and
   // queues a verdict when the request closes a text.
   task automatic absorb_request(input logic kind,
                                 input logic [subseq_pkg::SYMBOL_W-1:0] sym,
                                 input logic last);
      subseq_pkg::rsp_type verdict;
      if (kind == subseq_pkg::REQ_PATTERN) begin
         if (load_count == '0)
            overflow_flag = 1'b0;
         if (load_count < MAX_PATTERN) begin
            pattern_mem[load_count] = sym;
            load_count = load_count + 1'b1;
         end else begin
            overflow_flag = 1'b1;
         end
         if (last) begin
            pattern_len = load_count;
            load_count  = '0;
            match_ptr   = '0;
         end
      end else begin
         if (match_ptr < pattern_len && pattern_mem[match_ptr] == sym)
            match_ptr = match_ptr + 1'b1;
         if (last) begin
            verdict.found            = (match_ptr == pattern_len);
            verdict.pattern_overflow = overflow_flag;
            verdict_q.insert(verdict_q.size(), verdict);
            match_ptr = '0;
         end
      end
   endtask

   task automatic check_response(input logic found, input logic ovf);
      subseq_pkg::rsp_type want;
      if (verdict_q.size() == 0) begin
         mismatches++;
         $display("%0t: response with none expected, actual found=%0b overflow=%0b",
                  $time, found, ovf);
      end else begin
         want = verdict_q.pop_front();
         if (found !== want.found) begin
            mismatches++;
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, want.found, found);
         end
         if (ovf !== want.pattern_overflow) begin
            mismatches++;
            $display("%0t: pattern_overflow mismatch, expected %0b actual %0b",
                     $time, want.pattern_overflow, ovf);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pattern_len   = '0;
         load_count    = '0;
         match_ptr     = '0;
         overflow_flag = 1'b0;
         verdict_q.delete();
      end else begin
         if (req_valid && req_ready)
            absorb_request(req_type, req_symbol, req_is_last);
         if (rsp_valid && rsp_ready)
            check_response(rsp_found, rsp_pattern_overflow);
      end
      fail_count    <= mismatches;
      pending_count <= verdict_q.size();
   end

endmodule

// ===== dv/tb_subsequence_checker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subsequence checker testbench
// Streams patterns and texts into the checker under changing back-pressure
// and lets a scoreboard compare every verdict with its own prediction.
// ----------------------------------------------------------------------------
module tb_subsequence_checker_top;

   localparam int MAX_PATTERN   = 256;
   localparam int PHASE_ITEMS   = 380;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 400000;

   typedef logic [subseq_pkg::SYMBOL_W-1:0] symbol_type;

   // Shapes of text the random part produces. The embedded kinds carry the
   // current pattern in order with random filler between its bytes; the gap
   // kind leaves one pattern byte out; the open kind never sends a last byte.
   typedef enum int {
      TEXT_EMBED,
      TEXT_EMBED_GAP,
      TEXT_RANDOM,
      TEXT_OPEN
   } text_kind_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_type = subseq_pkg::REQ_PATTERN;
   symbol_type          req_symbol = '0;
   logic                req_is_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_found;
   logic                rsp_pattern_overflow;
   int                  fail_count;
   int                  pending_count;

   int                  send_idle_pct = 21;
   int                  recv_idle_pct = 88;
   logic                hold_token = 1'b0;
   logic                hold_seen = 1'b0;
   int                  hold_left = 0;
   int                  items_sent = 0;
   int                  cycle_count = 0;

   // The last completely loaded pattern, as far as the block can hold it.
   // Only used to build texts that contain it; prediction lives in the
   // scoreboard.
   symbol_type          stim_pattern[$];

   always #6 clock = ~clock;

   subsequence_checker_top #(
      .MAX_PATTERN(MAX_PATTERN)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_symbol          (req_symbol),
      .req_is_last         (req_is_last),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_found           (rsp_found),
      .rsp_pattern_overflow(rsp_pattern_overflow)
   );

   subseq_match_checker #(
      .MAX_PATTERN(MAX_PATTERN)
   ) match_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_symbol          (req_symbol),
      .req_is_last         (req_is_last),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_found           (rsp_found),
      .rsp_pattern_overflow(rsp_pattern_overflow),
      .fail_count          (fail_count),
      .pending_count       (pending_count)
   );

   // Watchdog. Even the slowest correct run finishes far below this count,
   // so reaching it means the block has hung somewhere.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side. Normally rsp_ready is rolled every cycle against the
   // idle percentage of the current phase. A toggle of hold_token starts a
   // long hold-off that this process counts down by itself, so the output
   // register and the skid register fill and the block has to drop
   // req_ready while the sender keeps offering requests.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic symbol_type pick_symbol(input logic narrow);
      // A narrow alphabet makes accidental matches common; the full one
      // exercises every bit of the symbol.
      return narrow ? symbol_type'($urandom_range(0, 3))
                    : symbol_type'($urandom_range(0, 255));
   endfunction

   // Offers one request and returns at the edge where its transfer happens.
   // Idle cycles are inserted before the request, never while it is
   // offered, so valid and payload stay put until accepted. If no idle
   // cycle is rolled, valid simply stays high into the next request.
   task automatic send_item(input logic kind, input symbol_type sym,
                            input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_symbol  <= sym;
      req_is_last <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Stops offering and waits until every queued verdict has come back.
   // The first edge is always waited for, so a transfer accepted at the
   // current edge is already counted when the count is looked at.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic send_text(input text_kind_type kind);
      symbol_type text_q[$];
      logic       narrow;
      int         skip;
      int         filler_max;
      int         tail;
      narrow = 1'($urandom_range(0, 1));
      // Long patterns get no filler, which keeps their texts short enough.
      filler_max = (stim_pattern.size() > 16) ? 0 : 2;
      skip = -1;
      if (kind == TEXT_EMBED_GAP && stim_pattern.size() != 0)
         skip = $urandom_range(0, stim_pattern.size() - 1);
      if (kind == TEXT_EMBED || kind == TEXT_EMBED_GAP) begin
         foreach (stim_pattern[i]) begin
            repeat ($urandom_range(0, filler_max))
               text_q.insert(text_q.size(), pick_symbol(narrow));
            if (i != skip)
               text_q.insert(text_q.size(), stim_pattern[i]);
         end
      end
      tail = (text_q.size() == 0) ? $urandom_range(1, 8) : $urandom_range(0, filler_max);
      repeat (tail) text_q.insert(text_q.size(), pick_symbol(narrow));
      foreach (text_q[i])
         send_item(subseq_pkg::REQ_TEXT, text_q[i],
                   (i == text_q.size() - 1) && (kind != TEXT_OPEN));
   endtask

   // Loads a pattern of the given length and follows it with texts. Now and
   // then a short text is pushed in before the pattern is fully loaded, which
   // matches against the old length and a maybe partly overwritten store.
   task automatic send_sequence(input int plen);
      symbol_type loaded[$];
      symbol_type sym;
      logic       narrow;
      int         cut;
      int         roll;
      narrow = 1'($urandom_range(0, 1));
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, plen - 1) : -1;
      for (int i = 0; i < plen; i++) begin
         if (i == cut)
            send_text(TEXT_RANDOM);
         sym = pick_symbol(narrow);
         send_item(subseq_pkg::REQ_PATTERN, sym, i == plen - 1);
         if (i < MAX_PATTERN)
            loaded.insert(loaded.size(), sym);
      end
      stim_pattern = loaded;
      if (plen > MAX_PATTERN) begin
         // Overflowed pattern: the flag must show on every verdict until
         // the next pattern starts.
         send_text(TEXT_RANDOM);
         send_text(TEXT_RANDOM);
      end else if (plen > 16) begin
         send_text(TEXT_EMBED);
         send_text(TEXT_RANDOM);
      end else begin
         repeat ($urandom_range(1, 4)) begin
            roll = $urandom_range(0, 19);
            if (roll < 10)
               send_text(TEXT_EMBED);
            else if (roll < 14)
               send_text(TEXT_EMBED_GAP);
            else if (roll < 19)
               send_text(TEXT_RANDOM);
            else
               send_text(TEXT_OPEN);
         end
      end
   endtask

   initial begin
      int phase_base;
      bit stalled;
      stalled = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A text before any pattern sees a pattern length of
      // zero and must report found.
      send_item(subseq_pkg::REQ_TEXT, 8'h00, 1'b1);
      send_item(subseq_pkg::REQ_TEXT, 8'hFF, 1'b0);
      send_item(subseq_pkg::REQ_TEXT, 8'h80, 1'b1);
      // One-byte pattern: found when present, not found when absent.
      send_item(subseq_pkg::REQ_PATTERN, 8'hFF, 1'b1);
      send_item(subseq_pkg::REQ_TEXT, 8'h00, 1'b0);
      send_item(subseq_pkg::REQ_TEXT, 8'hFF, 1'b1);
      send_item(subseq_pkg::REQ_TEXT, 8'h7F, 1'b1);
      // Two-byte pattern: order matters, filler in between does not.
      send_item(subseq_pkg::REQ_PATTERN, 8'h00, 1'b0);
      send_item(subseq_pkg::REQ_PATTERN, 8'h80, 1'b1);
      send_item(subseq_pkg::REQ_TEXT, 8'h80, 1'b0);
      send_item(subseq_pkg::REQ_TEXT, 8'h00, 1'b1);
      send_item(subseq_pkg::REQ_TEXT, 8'h00, 1'b0);
      send_item(subseq_pkg::REQ_TEXT, 8'h01, 1'b0);
      send_item(subseq_pkg::REQ_TEXT, 8'h80, 1'b1);
      // Text while a new pattern is half loaded: the first entry is already
      // replaced, but the old length of two still applies.
      send_item(subseq_pkg::REQ_PATTERN, 8'h55, 1'b0);
      send_item(subseq_pkg::REQ_TEXT, 8'h55, 1'b0);
      send_item(subseq_pkg::REQ_TEXT, 8'h80, 1'b1);
      send_item(subseq_pkg::REQ_PATTERN, 8'hAA, 1'b1);
      send_item(subseq_pkg::REQ_TEXT, 8'hAA, 1'b0);
      send_item(subseq_pkg::REQ_TEXT, 8'h55, 1'b1);
      // An unfinished text followed by a pattern: the pattern's last byte
      // must rewind the match pointer.
      send_item(subseq_pkg::REQ_TEXT, 8'h55, 1'b0);
      send_item(subseq_pkg::REQ_PATTERN, 8'h01, 1'b1);
      send_item(subseq_pkg::REQ_TEXT, 8'h01, 1'b1);
      wait_for_results();

      // Random part in three phases of back-pressure. Between phases the
      // sender pauses until every verdict has come back.
      for (int phase = 0; phase < 3; phase++) begin
         phase_base = items_sent;
         case (phase)
            0: begin
               send_idle_pct = 21;
               recv_idle_pct <= 88;
            end
            1: begin
               send_idle_pct = 88;
               recv_idle_pct <= 21;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase
         // A pattern that exactly fills the store, and later one that runs
         // past it and gets truncated.
         if (phase == 0)
            send_sequence(MAX_PATTERN);
         else if (phase == 1)
            send_sequence(MAX_PATTERN + $urandom_range(1, 8));
         while (items_sent < phase_base + PHASE_ITEMS) begin
            if (phase == 2 && !stalled && items_sent >= phase_base + 150) begin
               // Long receiver hold-off while a burst of closing text bytes
               // keeps the request side busy.
               stalled = 1'b1;
               hold_token <= ~hold_token;
               repeat (16) send_item(subseq_pkg::REQ_TEXT, pick_symbol(1'b0), 1'b1);
            end
            send_sequence($urandom_range(1, 10));
         end
         wait_for_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
design/subseq_pkg.sv
design/subseq_ram.sv
design/subsequence_checker_top.sv
dv/subseq_match_checker.sv
dv/tb_subsequence_checker_top.sv
